// ===== rtl/core/assert_macros.svh =====
//------------------------------------------------------------------------------
// assert_macros
// Assertion helper macros for the RTL.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge, held off during reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent check that runs during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/kwm_pkg.sv =====
//------------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants for the k-way sorted merge.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package kwm_pkg;
    localparam int MAX_ROWS    = 8;
    localparam int VALUE_WIDTH = 32;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int STORE_DEPTH = MAX_ROWS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int KCFG_W      = 4;
    localparam int ROWCNT_W    = $clog2(MAX_ROWS + 1);

    localparam logic [0:0] REG_K_USED = 1'b0;

    // Merge job handed from the loader to the merge engine.
    typedef struct packed {
        logic [ROWCNT_W-1:0] k;
    } job_t;

    // Store write bus from the loader.
    typedef struct packed {
        logic                   we;
        logic [ADDR_W-1:0]      addr;
        logic [VALUE_WIDTH-1:0] data;
    } wr_t;

    function automatic logic [ROWCNT_W-1:0] eff_k(input logic [KCFG_W-1:0] k);
        logic [ROWCNT_W-1:0] r;
        if (k == '0) r = ROWCNT_W'(1);
        else if (32'(k) > MAX_ROWS) r = ROWCNT_W'(MAX_ROWS);
        else r = ROWCNT_W'(k);
        return r;
    endfunction
endpackage

// ===== rtl/core/kwm_ram.sv =====
//------------------------------------------------------------------------------
// kwm_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/kwm_loader.sv =====
//------------------------------------------------------------------------------
// kwm_loader
// Front end: counts loaded words, writes the store and queues merge jobs.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module kwm_loader import kwm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [KCFG_W-1:0]      k_cfg,
    input  logic                   cfg_wr,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_value,
    output wr_t                    wr,
    output logic                   job_valid,
    output job_t                   job,
    input  logic                   job_ready,
    input  logic                   merge_active,
    output logic                   merge_busy
);
    logic [ROWCNT_W-1:0] k;
    logic [CNT_W-1:0]    total;
    logic [CNT_W-1:0]    load_count_reg, load_count_next;
    logic                pend_reg, pend_next;
    job_t                job_reg;
    logic                accept, done;

    assign k     = eff_k(k_cfg);
    assign total = CNT_W'(k) * CNT_W'(k);

    // Store holds one array only: stall loading while a merge is queued or running.
    assign s_ready    = !pend_reg && !merge_active;
    assign accept     = s_valid && s_ready;
    assign done       = accept && (load_count_reg + CNT_W'(1) >= total);
    assign job_valid  = pend_reg;
    assign job        = job_reg;
    assign merge_busy = pend_reg;

    assign wr.we   = accept;
    assign wr.addr = load_count_reg[ADDR_W-1:0];
    assign wr.data = s_value;

    always_comb begin
        load_count_next = load_count_reg;
        pend_next       = pend_reg;
        if (cfg_wr) load_count_next = '0;
        else if (accept) load_count_next = done ? '0 : load_count_reg + CNT_W'(1);
        if (done) pend_next = 1'b1;
        else if (job_ready) pend_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
            pend_reg       <= 1'b0;
        end else begin
            load_count_reg <= load_count_next;
            pend_reg       <= pend_next;
        end
        if (done) job_reg.k <= k;
    end
endmodule

// ===== rtl/core/kwm_merge.sv =====
//------------------------------------------------------------------------------
// kwm_merge
// Back end: selects the smallest row head, emits it and refetches that row.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module kwm_merge import kwm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   job_valid,
    input  job_t                   job,
    output logic                   job_ready,
    output logic [ADDR_W-1:0]      raddr,
    input  logic [VALUE_WIDTH-1:0] rdata,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_WIDTH-1:0] m_merged_value,
    output logic                   m_last,
    output logic                   active
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FILL  = 2'd1;
    localparam logic [1:0] ST_PICK  = 2'd2;
    localparam logic [1:0] ST_FETCH = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [ROWCNT_W-1:0]    k_reg;
    logic [VALUE_WIDTH-1:0] head_reg [MAX_ROWS];
    logic [ROWCNT_W-1:0]    col_reg  [MAX_ROWS];
    logic [ROW_W-1:0]       row_reg;
    logic                   rvld_reg, rvld_next;
    logic [CNT_W-1:0]       left_reg;
    logic                   ov_reg, ov_next;
    logic [VALUE_WIDTH-1:0] ov_data_reg;
    logic                   ov_last_reg;
    logic [ROW_W-1:0]       best;
    logic                   found;
    logic [VALUE_WIDTH-1:0] bv;
    logic [ADDR_W-1:0]      base;

    assign job_ready      = (state_reg == ST_IDLE);
    assign active         = (state_reg != ST_IDLE) || ov_reg;
    assign m_valid        = ov_reg;
    assign m_merged_value = ov_data_reg;
    assign m_last         = ov_last_reg;

    // Lowest row wins ties: strict less-than scanning upward.
    always_comb begin
        found = 1'b0;
        best  = '0;
        bv    = '0;
        for (int r = 0; r < MAX_ROWS; r++) begin
            if (ROWCNT_W'(r) < k_reg && col_reg[r] < k_reg) begin
                if (!found || $signed(head_reg[r]) < $signed(bv)) begin
                    found = 1'b1;
                    best  = ROW_W'(r);
                    bv    = head_reg[r];
                end
            end
        end
    end

    assign base  = ADDR_W'(row_reg) * ADDR_W'(k_reg);
    assign raddr = base + ADDR_W'(col_reg[row_reg]);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (job_valid) state_next = ST_FILL;
            ST_FILL:  if (rvld_reg && row_reg == ROW_W'(k_reg - 1'b1)) state_next = ST_PICK;
            ST_PICK:  if (!ov_reg || m_ready) begin
                if (left_reg == CNT_W'(1)) state_next = ST_IDLE;
                else state_next = ST_FETCH;
            end
            ST_FETCH: if (rvld_reg) state_next = ST_PICK;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Read strobe toggles in fill and fetch; output word clears on accept, loads on pick.
    always_comb begin
        rvld_next = ((state_reg == ST_FILL) || (state_reg == ST_FETCH)) && !rvld_reg;
        ov_next   = ov_reg;
        if (ov_reg && m_ready) ov_next = 1'b0;
        if (state_reg == ST_PICK && (!ov_reg || m_ready)) ov_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            rvld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rvld_reg  <= rvld_next;
            ov_reg    <= ov_next;
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        k_reg    <= job.k;
                        left_reg <= CNT_W'(job.k) * CNT_W'(job.k);
                        row_reg  <= '0;
                        for (int r = 0; r < MAX_ROWS; r++) col_reg[r] <= '0;
                    end
                end
                ST_FILL: begin
                    // Issue one row-head read per row and capture the registered read data on the strobe.
                    if (rvld_reg) begin
                        head_reg[row_reg] <= rdata;
                        if (row_reg != ROW_W'(k_reg - 1'b1)) row_reg <= row_reg + 1'b1;
                    end
                end
                ST_PICK: begin
                    if (!ov_reg || m_ready) begin
                        ov_data_reg <= bv;
                        ov_last_reg <= (left_reg == CNT_W'(1));
                        left_reg    <= left_reg - 1'b1;
                        col_reg[best] <= col_reg[best] + 1'b1;
                        row_reg     <= best;
                    end
                end
                ST_FETCH: begin
                    if (rvld_reg && col_reg[row_reg] < k_reg) head_reg[row_reg] <= rdata;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/core/k_way_sorted_merge.sv =====
//------------------------------------------------------------------------------
// k_way_sorted_merge
// Loads k sorted rows of k signed words and emits them merged in order.
//------------------------------------------------------------------------------
// Loading takes one word per cycle into a 64-entry store. When the last of the
// k*k words is in, the merge engine reads the k row heads, then emits the merged
// words one at a time: a scan over the k heads picks the smallest (lowest row on
// ties) and one store read refetches that row before the next pick.
// Input is held off from the final word until the merge has finished and the
// last merged word has been taken. The last merged word carries m_last. A write
// to k_used (0 acts as 1, above 8 as 8) drops any partial load; write it only
// while idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module k_way_sorted_merge import kwm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_WIDTH-1:0] m_merged_value,
    output logic                   m_last
);
    logic [KCFG_W-1:0]      k_used_reg;
    logic                   cfg_wr;
    wr_t                    wr;
    logic                   job_valid, job_ready, q_busy, active;
    job_t                   job;
    logic [ADDR_W-1:0]      raddr;
    logic [VALUE_WIDTH-1:0] rdata;

    // Register file: k_used at byte address 0.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[1:1] == REG_K_USED);
    assign prdata = (paddr == 2'd0) ? {28'd0, k_used_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) k_used_reg <= KCFG_W'(8);
        else if (cfg_wr) k_used_reg <= pwdata[KCFG_W-1:0];
    end

    kwm_loader u_loader (
        .aclk, .aresetn, .k_cfg(k_used_reg), .cfg_wr,
        .s_valid, .s_ready, .s_value, .wr,
        .job_valid, .job, .job_ready, .merge_active(active), .merge_busy(q_busy)
    );

    kwm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STORE_DEPTH)) u_store (
        .aclk, .we(wr.we), .waddr(wr.addr), .wdata(wr.data), .raddr, .rdata
    );

    kwm_merge u_merge (
        .aclk, .aresetn, .job_valid, .job, .job_ready, .raddr, .rdata,
        .m_valid, .m_ready, .m_merged_value, .m_last, .active
    );

    `ASSERT_CLK(a_no_load_when_queued, aclk, aresetn, q_busy |-> !s_ready, "load while job queued")
    `ASSERT_CLK(a_store_write_on_accept, aclk, aresetn, wr.we == (s_valid && s_ready), "stray write")
    `ASSERT_CLK(a_out_needs_merge, aclk, aresetn, m_valid |-> active, "output without merge")
endmodule

// ===== dv/tb_k_way_sorted_merge.sv =====
//------------------------------------------------------------------------------
// tb_k_way_sorted_merge
// Self-checking bench for the k-way sorted merge.
//------------------------------------------------------------------------------
// Loads square arrays of mostly sorted rows at several row counts, predicts the
// merged stream with a lowest-row-on-ties head scan, and checks every merged word
// and its last flag. Both channels idle at random, with one quiet stretch.
`timescale 1ns / 1ps
module tb_k_way_sorted_merge;
    import kwm_pkg::*;

    // Merge predictor and queue of expected merged words.
    class merge_scoreboard;
        logic [31:0] store_words[STORE_DEPTH];
        int          k_setting;
        int          loaded;
        logic [31:0] exp_value[$];
        bit          exp_last[$];
        int          errors;

        function new();
            k_setting = 8;
            loaded    = 0;
            errors    = 0;
        endfunction

        function int rows_used();
            int k;
            k = k_setting;
            if (k == 0) k = 1;
            if (k > MAX_ROWS) k = MAX_ROWS;
            return k;
        endfunction

        function void set_k(int k);
            k_setting = k;
            loaded    = 0;
        endfunction

        // Record one accepted input word; run the merge when the array fills.
        function void note_word(logic [31:0] v);
            int k;
            int head[MAX_ROWS];
            int best;
            k = rows_used();
            if (loaded >= k * k) loaded = 0;
            store_words[loaded] = v;
            loaded++;
            if (loaded < k * k) return;
            loaded = 0;
            for (int r = 0; r < k; r++) head[r] = 0;
            for (int n = 0; n < k * k; n++) begin
                best = -1;
                for (int r = 0; r < k; r++) begin
                    if (head[r] < k) begin
                        if (best < 0 || $signed(store_words[r*k+head[r]]) <
                                $signed(store_words[best*k+head[best]]))
                            best = r;
                    end
                end
                exp_value = {exp_value, store_words[best*k+head[best]]};
                exp_last  = {exp_last, bit'(n == k * k - 1)};
                head[best]++;
            end
        endfunction

        function void check_word(logic [31:0] v, logic l);
            logic [31:0] ev;
            bit el;
            if (exp_value.size() == 0) begin
                $error("merged_value: unexpected word %0d", $signed(v));
                errors++;
                return;
            end
            ev = exp_value.pop_front();
            el = exp_last.pop_front();
            if (v !== ev) begin
                $error("merged_value: expected %0d actual %0d", $signed(ev), $signed(v));
                errors++;
            end
            if (l !== el) begin
                $error("last: expected %0b actual %0b", el, l);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_merged_value;
    logic        m_last;

    merge_scoreboard sb = new();
    bit   quiet = 1'b0;     // suppress idling on both sides
    int   cycles = 0;
    localparam int CYCLE_LIMIT = 400000;

    always #2 aclk = ~aclk;

    k_way_sorted_merge dut (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_valid, .s_ready, .s_value, .m_valid, .m_ready, .m_merged_value, .m_last
    );

    // Watchdog: cap the run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Sample merged words at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_word(m_merged_value, m_last);
    end

    // Stall the result side about 11 percent of the time, outside the quiet stretch.
    always @(negedge aclk) begin
        m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);
    end

    // Write k_used with an APB setup and access phase; the block must be idle.
    task automatic write_k(input int k);
        s_valid <= 1'b0;
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_K_USED, 1'b0} << 0; pwdata <= k;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_k(k & 4'hf);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Present one word and hold it until accepted; call at a falling edge.
    task automatic send_word(input logic [31:0] v);
        while (!quiet && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(v);
        @(negedge aclk);
    endtask

    // Drop valid, wait for all expected words, then let the engine settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.exp_value.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Load one array: ascending rows, with random spread; noisy rows sometimes.
    task automatic send_array(input bit sorted, input int span);
        int k;
        logic [31:0] v;
        k = sb.rows_used();
        for (int r = 0; r < k; r++) begin
            v = $urandom();
            if (sorted && span < 1000) v = $urandom_range(2 * span) - span;
            for (int c = 0; c < k; c++) begin
                send_word(v);
                if (sorted) begin
                    if ($signed(v) > 32'sh7fff_0000) v = v;
                    else v = v + $urandom_range(span);
                end else
                    v = $urandom();
            end
        end
    endtask

    initial begin
        int kv;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset k, extremes, ties, descending rows.
        for (int i = 0; i < 2; i++) send_word(i ? 32'h7fff_ffff : 32'h8000_0000);
        write_k(2);
        send_word(32'h8000_0000); send_word(32'h7fff_ffff);
        send_word(32'h8000_0000); send_word(32'h7fff_ffff);
        drain();
        write_k(2);
        send_word(5); send_word(5); send_word(5); send_word(5);
        drain();
        write_k(2);
        send_word(9); send_word(-9); send_word(3); send_word(-3);
        drain();
        write_k(0);
        send_word(32'hffff_ffff);
        send_word(0);
        drain();
        write_k(15);
        drain();
        // Reset-default k left a partial load of two words; k write dropped it.

        // Random: mostly sorted arrays over several row counts.
        for (int phase = 0; phase < 20; phase++) begin
            kv = (phase % 6 == 0) ? 8 : $urandom_range(1, 5);
            if (phase == 3) kv = 1;
            quiet = (phase >= 8 && phase < 11);
            write_k(kv);
            send_array(($urandom_range(9) != 0), (phase % 2) ? 5 : 100000000);
            if (phase == 12) send_word($urandom());   // partial load, dropped by next write
            drain();
        end
        quiet = 1'b0;
        drain();
        if (sb.errors == 0 && sb.exp_value.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/kwm_pkg.sv
rtl/core/kwm_ram.sv
rtl/core/kwm_loader.sv
rtl/core/kwm_merge.sv
rtl/core/k_way_sorted_merge.sv
dv/tb_k_way_sorted_merge.sv
